>>> sv/assert_macros.svh
// Assertion macros used by the checker.
// Each macro samples on posedge clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every sampled edge.
`define AST_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define AST_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AST_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/lfpr_pkg.sv
// Package for the length-framed packet receiver.
// Holds frame geometry, receive phase and status codes; no dependencies.
`default_nettype none

package lfpr_pkg;

	localparam int HEADER_SIZE = 2;
	localparam int LENGTH_POS  = 1;
	localparam int BUFFER_SIZE = 64;

	// stored-byte counter must hold BUFFER_SIZE itself
	localparam int CNT_W = $clog2(BUFFER_SIZE + 1);
	// width for header size plus payload length compares
	localparam int SUM_W = ((CNT_W > 8) ? CNT_W : 8) + 2;

	localparam int POS_W     = 6;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_BYTE  = 1'b0,
		CFG_MAX_PAYLOAD = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_HEADER = 3'd1,
		PH_DATA   = 3'd2,
		PH_CHECK  = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_BAD_SUM  = 2'd2
	} status_t;

endpackage

`default_nettype wire

>>> sv/length_framed_packet_receiver_unit.sv
// Top level of the length-framed packet receiver.
// Depends on lfpr_pkg for frame geometry, phase and status codes.
`default_nettype none

// Receives one byte per transfer on the slave stream and returns exactly one
// result per byte on the master stream. The receiver hunts for the start byte
// (cfg register 0), then stores HEADER_SIZE header bytes; the header byte at
// LENGTH_POS gives the payload length. A zero last header byte skips the
// payload. One checksum byte closes the frame and the result carries
// m_tlast with a status in m_tuser: good, payload longer than cfg register 1,
// or nonzero XOR over all stored bytes (too long wins). Any byte after a
// closed frame, or after BUFFER_SIZE stored bytes, restarts the hunt and is
// itself treated as a hunt byte. Throughput is one byte per clock while the
// result stream is not stalled; a byte passes through the input register, then
// the result register that the phase/count/XOR update feeds. The only loop is
// the state update, so back-to-back bytes stall only while a held result waits
// on m_tready. No clearing pass after reset: the block is ready out of reset.
// Configuration must only be written while no byte is in flight.
module length_framed_packet_receiver_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [lfpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lfpr_pkg::CFG_DAT_W-1:0] cfg_data,
	// received bytes
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [7:0]                     s_tdata,   // [7:0] rx_byte
	// results
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [15:0]                         m_tdata,   // [7:0] data_byte,
	                                                       // [13:8] data_pos,
	                                                       // [14] data_valid, [15] zero
	output logic                                m_tlast,   // frame_end
	output logic [1:0]                          m_tuser    // [1:0] frame_status
);
	import lfpr_pkg::*;

	// configuration registers
	logic [7:0] start_q;
	logic [7:0] max_len_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;

	// frame state
	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [7:0]       len_q, len_d;
	logic [7:0]       xor_q, xor_d;

	// result register
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic [POS_W-1:0] out_pos_q;
	logic             out_stored_q;
	logic             out_end_q;
	status_t          out_status_q;

	// combinational step results
	phase_t           eff_phase;
	logic [CNT_W-1:0] eff_count;
	logic [7:0]       eff_len;
	logic [7:0]       eff_xor;
	logic             restart;
	logic             stored;
	logic             frame_end;
	status_t          status;
	logic [CNT_W-1:0] next_count;
	logic [SUM_W-1:0] next_count_w;
	logic [SUM_W-1:0] frame_len_w;

	// Config writes: take them whenever the enable is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= 8'd2;
			max_len_q <= 8'd32;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_START_BYTE:  start_q   <= cfg_data;
				CFG_MAX_PAYLOAD: max_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the input stage whenever the result register is free or drains.
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// Frame state register: update only when the held byte moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			len_q   <= '0;
			xor_q   <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			count_q <= count_d;
			len_q   <= len_d;
			xor_q   <= xor_d;
		end
	end

	// Next-state and result logic for the byte in the input stage.
	always_comb begin
		// A closed frame or a full buffer drops the old frame before this byte.
		restart   = (phase_q == PH_DONE) || (count_q >= CNT_W'(BUFFER_SIZE));
		eff_phase = restart ? PH_HUNT : phase_q;
		eff_count = restart ? '0 : count_q;
		eff_len   = restart ? '0 : len_q;
		eff_xor   = restart ? '0 : xor_q;

		stored    = (eff_phase == PH_HEADER) || (eff_phase == PH_DATA)
			|| (eff_phase == PH_CHECK);
		frame_end = 1'b0;
		status    = ST_GOOD;

		next_count   = eff_count + CNT_W'(1);
		next_count_w = SUM_W'(next_count);

		phase_d = eff_phase;
		count_d = eff_count;
		len_d   = eff_len;
		xor_d   = eff_xor;

		if (stored) begin
			count_d = next_count;
			xor_d   = eff_xor ^ byte_s1;
			if (SUM_W'(eff_count) == SUM_W'(LENGTH_POS)) begin
				len_d = byte_s1;
			end
		end

		frame_len_w = SUM_W'(HEADER_SIZE) + SUM_W'(len_d);

		unique case (eff_phase)
			PH_HEADER: begin
				if (next_count_w == SUM_W'(HEADER_SIZE)) begin
					phase_d = (byte_s1 != 8'd0) ? PH_DATA : PH_CHECK;
				end
			end
			PH_DATA: begin
				if (next_count_w == frame_len_w) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				phase_d   = PH_DONE;
				frame_end = 1'b1;
				if (len_d > max_len_q) begin
					status = ST_TOO_LONG;
				end else if (xor_d != 8'd0) begin
					status = ST_BAD_SUM;
				end
			end
			default: begin
				// hunting: unused codes land here as well
				phase_d = (byte_s1 == start_q) ? PH_HEADER : PH_HUNT;
			end
		endcase
	end

	// Result register: load on advance, clear valid once the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q   <= stored ? byte_s1 : 8'd0;
			out_pos_q    <= stored ? eff_count[POS_W-1:0] : '0;
			out_stored_q <= stored;
			out_end_q    <= frame_end;
			out_status_q <= status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_stored_q, out_pos_q, out_byte_q};
	assign m_tlast  = out_end_q;
	assign m_tuser  = out_status_q;

endmodule

`default_nettype wire

>>> sv/lfpr_checker.sv
// Port-level checker for the length-framed packet receiver, bound to the top.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module lfpr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic [1:0]  m_tuser
);

	// a frame end is always a stored byte
	`AST_IMPLY(a_end_stored, m_tvalid && m_tlast, m_tdata[14], "frame end on unstored byte")
	// a status only accompanies a frame end
	`AST_IMPLY(a_status_end, m_tvalid && (m_tuser != 2'd0), m_tlast, "status without frame end")
	// unstored results carry zero byte and position
	`AST_IMPLY(a_idle_zero, m_tvalid && !m_tdata[14], m_tdata[13:0] == 14'd0,
		"unstored result not zero")
	// a stalled result holds
	`AST_NEXT(a_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser),
		"stalled result changed")
	// input only backs up behind a stalled result
	`AST_IMPLY(a_backpressure, s_tvalid && !s_tready, m_tvalid && !m_tready,
		"input stalled while result path free")

endmodule

bind length_framed_packet_receiver_unit lfpr_checker u_lfpr_checker (.*);

`default_nettype wire

>>> bench/tb_length_framed_packet_receiver_unit.sv
`timescale 1ns / 1ps
// Testbench for length_framed_packet_receiver_unit: directed frames, then random frames.
// Depends on lfpr_pkg and the receiver RTL; predicts every result and compares it in order.

module tb_length_framed_packet_receiver_unit;

	import lfpr_pkg::*;

	// Cycles without any transfer on either stream before the run is declared hung.
	localparam int STALL_LIMIT = 1000;
	// Random stimulus stops after about this many received bytes.
	localparam int RANDOM_BYTES = 725;
	// Cycles to hold off after the last result before touching config or ending.
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic [POS_W-1:0] data_pos;
		logic             data_valid;
		logic             frame_end;
		logic [1:0]       frame_status;
	} result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;   // [7:0] rx_byte
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [15:0]          m_tdata;        // [7:0] data_byte, [13:8] data_pos, [14] data_valid
	logic                 m_tlast;        // frame_end
	logic [1:0]           m_tuser;        // [1:0] frame_status

	length_framed_packet_receiver_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	// Receiver model: its own copy of the registers and the framing state.
	logic [7:0]       cfg_start = 8'd2;
	logic [7:0]       cfg_max   = 8'd32;
	phase_t           rx_ph     = PH_HUNT;
	logic [CNT_W-1:0] rx_cnt    = '0;
	logic [7:0]       rx_len    = '0;
	logic [7:0]       rx_xor    = '0;

	result_t pending_results[$];
	int      mismatch_count = 0;
	int      bytes_sent = 0;
	bit      src_steady = 1'b0;   // sender drives back to back while set
	bit      sink_steady = 1'b0;  // receiver keeps tready high while set

	initial begin
		forever #5 clk = ~clk;
	end

	// Advance the framing state by one byte and return the result it must produce.
	function automatic result_t predict_result(input logic [7:0] b);
		result_t r;
		r = '0;
		// A closed frame or a full buffer restarts the hunt before the byte is looked at.
		if (rx_ph == PH_DONE || rx_cnt >= BUFFER_SIZE) begin
			rx_ph  = PH_HUNT;
			rx_cnt = '0;
			rx_len = '0;
			rx_xor = '0;
		end
		if (rx_ph == PH_HEADER || rx_ph == PH_DATA || rx_ph == PH_CHECK) begin
			r.data_valid = 1'b1;
			r.data_byte  = b;
			r.data_pos   = rx_cnt[POS_W-1:0];
			if (rx_cnt == LENGTH_POS) begin
				rx_len = b;
			end
			rx_xor = rx_xor ^ b;
			rx_cnt = rx_cnt + 1'b1;
			if (rx_ph == PH_HEADER) begin
				// a zero last header byte skips the payload
				if (rx_cnt == HEADER_SIZE) begin
					rx_ph = (b != 8'd0) ? PH_DATA : PH_CHECK;
				end
			end else if (rx_ph == PH_DATA) begin
				if (rx_cnt == HEADER_SIZE + rx_len) begin
					rx_ph = PH_CHECK;
				end
			end else begin
				// checksum byte: too long wins over a bad sum
				rx_ph       = PH_DONE;
				r.frame_end = 1'b1;
				if (rx_len > cfg_max) begin
					r.frame_status = ST_TOO_LONG;
				end else if (rx_xor != 8'd0) begin
					r.frame_status = ST_BAD_SUM;
				end else begin
					r.frame_status = ST_GOOD;
				end
			end
		end else begin
			rx_ph = (b == cfg_start) ? PH_HEADER : PH_HUNT;
		end
		return r;
	endfunction

	// Offer one byte after a random gap and hold it until the transfer.
	// Enter and leave at a rising edge; tvalid stays high when the next gap is zero.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = src_steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(predict_result(b));
		bytes_sent++;
	endtask

	// Send start byte, header (first byte, length byte), payload and checksum.
	// sum_flip corrupts the checksum; cut >= 0 stops after that many bytes.
	task automatic send_frame(input logic [7:0] hdr0, input logic [7:0] len,
			input logic [7:0] sum_flip, input int cut);
		logic [7:0] frame_q[$];
		logic [7:0] sum;
		logic [7:0] pb;
		frame_q.push_back(cfg_start);
		frame_q.push_back(hdr0);
		frame_q.push_back(len);
		sum = hdr0 ^ len;
		for (int i = 0; i < len; i++) begin
			pb = 8'($urandom);
			frame_q.push_back(pb);
			sum = sum ^ pb;
		end
		frame_q.push_back(sum ^ sum_flip);
		for (int k = 0; k < frame_q.size(); k++) begin
			if (cut >= 0 && k >= cut) break;
			send_byte(frame_q[k]);
		end
	endtask

	// Drop tvalid, wait for every pending result, then let the pipeline settle.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers once the block is idle.
	task automatic set_config(input logic [7:0] start_val, input logic [7:0] max_val);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_START_BYTE;
		cfg_data  <= start_val;
		@(posedge clk);
		cfg_start = start_val;
		cfg_index <= CFG_MAX_PAYLOAD;
		cfg_data  <= max_val;
		@(posedge clk);
		cfg_max = max_val;
		cfg_we <= 1'b0;
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// Result sink: stall at random, then compare each transfer with the oldest expectation.
	initial begin : result_sink
		int      stall;
		result_t want;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = sink_steady ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: tdata %h tlast %b tuser %h",
					m_tdata, m_tlast, m_tuser);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("data_byte", want.data_byte, m_tdata[7:0]);
				check_field("data_pos", want.data_pos, m_tdata[13:8]);
				check_field("data_valid", want.data_valid, m_tdata[14]);
				check_field("tdata_pad", 0, m_tdata[15]);
				check_field("frame_end", want.frame_end, m_tlast);
				check_field("frame_status", want.frame_status, m_tuser);
			end
			// switch between stalling and always-ready stretches now and then
			if ($urandom_range(0, 31) == 0) sink_steady = ~sink_steady;
		end
	end

	// Hang detector: count cycles with no transfer on either stream.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Bytes that never match the reset start byte stay in the hunt.
	task automatic test_hunt_noise();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h5A);
	endtask

	// Reset registers: good frame, zero length, bad checksum; frames abut directly,
	// so each start byte lands right after a checksum.
	task automatic test_default_frames();
		send_frame(8'h11, 8'd2, 8'h00, -1);
		send_frame(8'hFF, 8'd0, 8'h00, -1);
		send_frame(8'h00, 8'd1, 8'h80, -1);
	endtask

	// Extremes of both registers: too long alone, too long with a bad sum, widest limit.
	task automatic test_register_limits();
		set_config(8'hFF, 8'h00);
		send_frame(8'hFF, 8'd1, 8'h00, -1);
		send_frame(8'h00, 8'd1, 8'h01, -1);
		set_config(8'h00, 8'hFF);
		send_frame(8'hFF, 8'd3, 8'h00, -1);
	endtask

	// Fill the buffer: a huge length runs to BUFFER_SIZE stored bytes, and a length
	// that ends exactly at the buffer size turns its checksum into a hunt byte.
	task automatic test_buffer_full();
		set_config(8'h02, 8'hFF);
		send_frame(8'h33, 8'hFF, 8'h00, 3 + BUFFER_SIZE - HEADER_SIZE);
		send_frame(8'h44, 8'd1, 8'h00, -1);
		send_frame(8'h55, 8'(BUFFER_SIZE - HEADER_SIZE), 8'h00, -1);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
	endtask

	// Mostly well-formed frames with random content, some cut short, some noise;
	// reconfigure every so often, extremes included.
	task automatic test_random_traffic();
		int         stop_at;
		int         next_cfg;
		int         pick;
		logic [7:0] s_val;
		logic [7:0] m_val;
		logic [7:0] len;
		logic [7:0] flip;
		logic [7:0] nb;
		stop_at  = bytes_sent + RANDOM_BYTES;
		next_cfg = bytes_sent;
		while (bytes_sent < stop_at) begin
			if (bytes_sent >= next_cfg) begin
				pick  = $urandom_range(0, 3);
				s_val = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
				pick  = $urandom_range(0, 3);
				m_val = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF :
					(pick == 2) ? 8'($urandom_range(0, 8)) : 8'($urandom);
				set_config(s_val, m_val);
				next_cfg = bytes_sent + 150;
			end
			src_steady = ($urandom_range(0, 3) == 0);
			len  = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
			flip = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				// a little line noise that cannot start a frame, then a whole frame
				repeat ($urandom_range(0, 2)) begin
					do nb = 8'($urandom); while (nb == cfg_start);
					send_byte(nb);
				end
				send_frame(8'($urandom), len, flip, -1);
			end else if (pick < 9) begin
				send_frame(8'($urandom), len, flip, $urandom_range(1, 4 + len));
			end else begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			end
		end
		src_steady = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_hunt_noise();
		test_default_frames();
		test_register_limits();
		test_buffer_full();
		test_random_traffic();
		// hold the sender until everything is back, then give the pipeline time
		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
